// ----- rtl/edrm_pkg.sv -----
// ============================================================================
// edrm_pkg: shared types and constants of the descriptor ring manager
// Operation and result codes, flag positions and the command record passed
// from the front end to the back end.
// ============================================================================
package edrm_pkg;

  localparam int unsigned TxSlotsDefault     = 8;
  localparam int unsigned RxSlotsDefault     = 8;
  localparam int unsigned BufferBytesDefault = 2048;

  localparam int unsigned OpW   = 3;
  localparam int unsigned SlotW = 6;
  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 16;
  localparam int unsigned StatW = 8;
  localparam int unsigned TotW  = 22;
  localparam int unsigned MaskW = 7;

  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_GRANT  = 3'd1;
  localparam logic [2:0] OP_SUBMIT = 3'd2;
  localparam logic [2:0] OP_POLL   = 3'd3;
  localparam logic [2:0] OP_TXDONE = 3'd4;
  localparam logic [2:0] OP_RXDONE = 3'd5;

  localparam logic [2:0] K_GRANT  = 3'd0;
  localparam logic [2:0] K_REFUSE = 3'd1;
  localparam logic [2:0] K_QUEUED = 3'd2;
  localparam logic [2:0] K_FRAME  = 3'd3;
  localparam logic [2:0] K_DONE   = 3'd4;
  localparam logic [2:0] K_ACK    = 3'd5;

  localparam logic [0:0] REG_DATA_BASE = 1'b0;
  localparam logic [0:0] REG_ERR_MASK  = 1'b1;

  // Status flags (low half of the status word).
  localparam logic [15:0] TXF_READY = 16'h8000;
  localparam logic [15:0] TXF_IRQ   = 16'h4000;
  localparam logic [15:0] TXF_WRAP  = 16'h2000;
  localparam logic [15:0] TXF_PAD   = 16'h1000;
  localparam logic [15:0] TXF_CRC   = 16'h0800;
  localparam logic [15:0] TXF_STATS = 16'h01FF;
  localparam logic [15:0] RXF_EMPTY = 16'h8000;
  localparam logic [15:0] RXF_IRQ   = 16'h4000;
  localparam logic [15:0] RXF_WRAP  = 16'h2000;
  localparam logic [15:0] RXF_STATS = 16'h00FF;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    logic [StatW-1:0] sbits;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    logic [TotW-1:0]  total;
    logic             last;
  } res_t;

endpackage

// ----- rtl/edrm_front.sv -----
// ============================================================================
// edrm_front: input stage and command queue
// Accepts input transfers and holds up to two commands for the back end.
// ============================================================================
module edrm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  edrm_pkg::cmd_t    in_cmd_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output edrm_pkg::cmd_t    cmd_o
);

  edrm_pkg::cmd_t entry_q [2];
  edrm_pkg::cmd_t entry_d;
  logic [1:0] count_q, count_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    // Codes six and seven pass through; the back end answers them with an
    // acknowledge and no side effect.
    entry_d = in_cmd_i;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
    rd_d    = rd_q ^ pop;
    wr_d    = wr_q ^ push;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= entry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rd_q    <= 1'b0;
      wr_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
    end
  end

endmodule

// ----- rtl/edrm_back.sv -----
// ============================================================================
// edrm_back: ring engine
// Holds both descriptor rings and carries out one command at a time,
// walking the receive ring one slot per cycle during a poll while the output stage is free.
// ============================================================================
module edrm_back #(
  parameter int unsigned TxSlots     = edrm_pkg::TxSlotsDefault,
  parameter int unsigned RxSlots     = edrm_pkg::RxSlotsDefault,
  parameter int unsigned BufferBytes = edrm_pkg::BufferBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       data_base_i,
  input  logic [6:0]        err_mask_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  edrm_pkg::cmd_t    cmd_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output edrm_pkg::res_t    res_o
);

  localparam int unsigned TxW = (TxSlots > 1) ? $clog2(TxSlots) : 1;
  localparam int unsigned RxW = (RxSlots > 1) ? $clog2(RxSlots) : 1;
  localparam logic [TxW-1:0] TxLast = TxW'(TxSlots - 1);
  localparam logic [RxW-1:0] RxLast = RxW'(RxSlots - 1);
  localparam logic [31:0] BufB = 32'(BufferBytes);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;

  logic [1:0]  state_q, state_d;
  logic [31:0] tx_word_q [TxSlots];
  logic [31:0] tx_addr_q [TxSlots];
  logic [31:0] rx_word_q [RxSlots];
  logic [31:0] rx_addr_q [RxSlots];
  logic [TxW-1:0] give_q, send_q;
  logic           full_q;
  logic [RxW-1:0] chk_q;
  logic [RxW:0]   steps_q;
  logic [edrm_pkg::TotW-1:0] total_q;
  logic           res_valid_q;
  edrm_pkg::res_t res_q;

  logic [31:0] rw;
  logic        out_free;
  logic        walk_end;

  assign out_free    = !res_valid_q || res_ready_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign rw          = rx_word_q[chk_q];
  assign walk_end    = (state_q == S_WALK) && out_free
                       && (rw[15] || steps_q == (RxW+1)'(RxSlots));
  // A poll stays at the head of the queue during the walk and is released
  // together with its done result.
  assign cmd_ready_o = walk_end || ((state_q == S_IDLE) && out_free
                       && (cmd_i.op != edrm_pkg::OP_POLL));

  function automatic logic [TxW-1:0] nxt_tx(input logic [TxW-1:0] p);
    return (p == TxLast) ? '0 : p + 1'b1;
  endfunction
  function automatic logic [RxW-1:0] nxt_rx(input logic [RxW-1:0] p);
    return (p == RxLast) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_valid_i && cmd_i.op == edrm_pkg::OP_POLL) state_d = S_WALK;
      S_WALK: if (walk_end) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      give_q      <= '0;
      send_q      <= '0;
      full_q      <= 1'b0;
      chk_q       <= '0;
      steps_q     <= '0;
      total_q     <= '0;
      for (int i = 0; i < TxSlots; i++) begin
        tx_word_q[i] <= {16'd0, edrm_pkg::TXF_PAD | edrm_pkg::TXF_CRC | edrm_pkg::TXF_IRQ
                         | ((i == TxSlots - 1) ? edrm_pkg::TXF_WRAP : 16'd0)};
        tx_addr_q[i] <= 32'(i) * BufB;
      end
      for (int i = 0; i < RxSlots; i++) begin
        rx_word_q[i] <= {16'd0, edrm_pkg::RXF_EMPTY | edrm_pkg::RXF_IRQ
                         | ((i == RxSlots - 1) ? edrm_pkg::RXF_WRAP : 16'd0)};
        rx_addr_q[i] <= 32'(TxSlots + i) * BufB;
      end
    end else begin
      state_q <= state_d;
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      if (state_q == S_IDLE && cmd_valid_i && cmd_i.op == edrm_pkg::OP_POLL) begin
        steps_q <= '0;
        total_q <= '0;
      end
      if (state_q == S_IDLE && cmd_valid_i && cmd_ready_o) begin
        res_valid_q <= 1'b1;
        res_q <= '{kind: edrm_pkg::K_ACK, addr: '0, len: '0, total: '0, last: 1'b1};
        unique case (cmd_i.op)
          edrm_pkg::OP_INIT: begin
            give_q <= '0;
            send_q <= '0;
            full_q <= 1'b0;
            chk_q  <= '0;
            for (int i = 0; i < TxSlots; i++) begin
              tx_word_q[i] <= {16'd0, edrm_pkg::TXF_PAD | edrm_pkg::TXF_CRC
                               | edrm_pkg::TXF_IRQ
                               | ((i == TxSlots - 1) ? edrm_pkg::TXF_WRAP : 16'd0)};
              tx_addr_q[i] <= data_base_i + 32'(i) * BufB;
            end
            for (int i = 0; i < RxSlots; i++) begin
              rx_word_q[i] <= {16'd0, edrm_pkg::RXF_EMPTY | edrm_pkg::RXF_IRQ
                               | ((i == RxSlots - 1) ? edrm_pkg::RXF_WRAP : 16'd0)};
              rx_addr_q[i] <= data_base_i + 32'(TxSlots + i) * BufB;
            end
          end
          edrm_pkg::OP_GRANT: begin
            if (full_q || tx_word_q[give_q][15]) begin
              res_q.kind <= edrm_pkg::K_REFUSE;
            end else begin
              res_q.kind <= edrm_pkg::K_GRANT;
              res_q.addr <= tx_addr_q[give_q];
              give_q     <= nxt_tx(give_q);
              if (nxt_tx(give_q) == send_q) full_q <= 1'b1;
            end
          end
          edrm_pkg::OP_SUBMIT: begin
            tx_addr_q[send_q] <= cmd_i.addr;
            tx_word_q[send_q] <= {cmd_i.len, (tx_word_q[send_q][15:0]
                                  & ~edrm_pkg::TXF_STATS) | edrm_pkg::TXF_READY};
            send_q     <= nxt_tx(send_q);
            full_q     <= 1'b0;
            res_q.kind <= edrm_pkg::K_QUEUED;
          end
          edrm_pkg::OP_TXDONE: begin
            if (32'(cmd_i.slot) < TxSlots)
              tx_word_q[cmd_i.slot[TxW-1:0]] <=
                {tx_word_q[cmd_i.slot[TxW-1:0]][31:16], 1'b0,
                 tx_word_q[cmd_i.slot[TxW-1:0]][14:8], cmd_i.sbits};
          end
          edrm_pkg::OP_RXDONE: begin
            if (32'(cmd_i.slot) < RxSlots)
              rx_word_q[cmd_i.slot[RxW-1:0]] <=
                {cmd_i.len, 1'b0, rx_word_q[cmd_i.slot[RxW-1:0]][14:8], cmd_i.sbits};
          end
          default: ;
        endcase
      end
      if (state_q == S_WALK && out_free) begin
        res_valid_q <= 1'b0;
        if (rw[15] || steps_q == (RxW+1)'(RxSlots)) begin
          res_valid_q <= 1'b1;
          res_q <= '{kind: edrm_pkg::K_DONE, addr: '0, len: '0, total: total_q, last: 1'b1};
        end else begin
          if ((rw[6:0] & err_mask_i) == 7'd0) begin
            res_valid_q <= 1'b1;
            res_q <= '{kind: edrm_pkg::K_FRAME, addr: rx_addr_q[chk_q], len: rw[31:16],
                       total: '0, last: 1'b0};
            total_q <= total_q + edrm_pkg::TotW'(rw[31:16]);
          end
          rx_word_q[chk_q] <= {rw[31:16], (rw[15:0] & ~edrm_pkg::RXF_STATS)
                               | edrm_pkg::RXF_EMPTY};
          chk_q   <= nxt_rx(chk_q);
          steps_q <= steps_q + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/eth_descriptor_ring_manager.sv -----
// An accepted input transfer waits in the front-end queue; its result is registered in the output stage.
// Throughput: one ring operation per cycle once queued, while the output stage is free; a receive
// poll first enters the walk state, walks at most RxSlots slots and then gives the done result.
// Reset (rst_ni, asynchronous, active low) rebuilds both pools with a zero
// base address, clears every pointer and sets the error mask to all ones.
// ============================================================================
// eth_descriptor_ring_manager: buffer-descriptor ring manager
// The front end queues commands; the back end keeps the rings and emits
// results through a registered output stage.
// ============================================================================
module eth_descriptor_ring_manager #(
  parameter int unsigned TxSlots     = edrm_pkg::TxSlotsDefault,
  parameter int unsigned RxSlots     = edrm_pkg::RxSlotsDefault,
  parameter int unsigned BufferBytes = edrm_pkg::BufferBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[2:0], slot[8:3], buffer_address[40:9], frame_length[56:41],
  // status_bits[64:57], zero fill
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_address[31:0], out_length[47:32], total_length[69:48], zero fill
  output logic [71:0] m_axis_tdata,
  // kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  edrm_pkg::cmd_t in_cmd, cmd;
  edrm_pkg::res_t res;
  logic           cmd_valid, cmd_ready;
  logic [31:0]    data_base_q;
  logic [6:0]     err_mask_q;

  assign in_cmd = '{op: s_axis_tdata[2:0], slot: s_axis_tdata[8:3],
                    addr: s_axis_tdata[40:9], len: s_axis_tdata[56:41],
                    sbits: s_axis_tdata[64:57]};

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_base_q <= '0;
      err_mask_q  <= 7'h7F;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        edrm_pkg::REG_DATA_BASE: data_base_q <= cfg_data_i;
        default:                 err_mask_q  <= cfg_data_i[6:0];
      endcase
    end
  end

  edrm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (in_cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  edrm_back #(.TxSlots(TxSlots), .RxSlots(RxSlots), .BufferBytes(BufferBytes)) u_back (
    .clk_i, .rst_ni,
    .data_base_i(data_base_q),
    .err_mask_i (err_mask_q),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {2'd0, res.total, res.len, res.addr};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ----- bench/tb_eth_descriptor_ring_manager.sv -----
// ============================================================================
// tb_eth_descriptor_ring_manager: self-checking bench for the ring manager
// Drives ring operations and MAC completion events through the input stream,
// predicts every result transfer with a behavioural copy of both rings and
// compares the output stream field by field, under random idling and stalls.
// ============================================================================
module tb_eth_descriptor_ring_manager;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NTx  = edrm_pkg::TxSlotsDefault;
  localparam int unsigned NRx  = edrm_pkg::RxSlotsDefault;
  localparam int unsigned BufB = edrm_pkg::BufferBytesDefault;
  localparam int unsigned IdleLimit = 20000;

  // One expected output transfer.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [15:0] len;
    logic [21:0] total;
    logic        last;
  } ring_result_t;

  // One stimulus row; chk_first asks for the typed-in first result to be
  // compared against the prediction as well.
  typedef struct {
    logic [2:0]   op;
    logic [5:0]   slot;
    logic [31:0]  addr;
    logic [15:0]  len;
    logic [7:0]   sbits;
    bit           chk_first;
    ring_result_t first;
  } ring_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = edrm_pkg::REG_DATA_BASE;
  logic [31:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  eth_descriptor_ring_manager u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // Predicted ring state, kept in step with every accepted input transfer.
  logic [31:0] base_q;
  logic [6:0]  err_mask_q;
  logic [31:0] tx_word [NTx];
  logic [31:0] tx_buf  [NTx];
  logic [31:0] rx_word [NRx];
  logic [31:0] rx_buf  [NRx];
  int unsigned tx_give, tx_send, rx_check;
  bit          tx_full;

  ring_result_t pending_results[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  rx_hold = 1'b0;   // long receiver hold-off in progress
  bit  no_idle = 1'b0;   // stretch with no random idling

  function automatic ring_result_t mk(logic [2:0] k, logic [31:0] a = '0,
                                      logic [15:0] l = '0, logic [21:0] t = '0,
                                      logic lst = 1'b1);
    ring_result_t r;
    r.kind = k; r.addr = a; r.len = l; r.total = t; r.last = lst;
    return r;
  endfunction

  function automatic void rebuild_rings();
    for (int i = 0; i < NTx; i++) begin
      tx_word[i] = {16'h0, edrm_pkg::TXF_PAD | edrm_pkg::TXF_CRC | edrm_pkg::TXF_IRQ};
      tx_buf[i]  = base_q + i * BufB;
    end
    tx_word[NTx-1] |= {16'h0, edrm_pkg::TXF_WRAP};
    for (int i = 0; i < NRx; i++) begin
      rx_word[i] = {16'h0, edrm_pkg::RXF_EMPTY | edrm_pkg::RXF_IRQ};
      rx_buf[i]  = base_q + (NTx + i) * BufB;
    end
    rx_word[NRx-1] |= {16'h0, edrm_pkg::RXF_WRAP};
    tx_give = 0; tx_send = 0; tx_full = 1'b0; rx_check = 0;
  endfunction

  // Applies one command to the predicted rings and queues its results.
  function automatic void predict_ring_op(logic [2:0] op, logic [5:0] slot,
                                          logic [31:0] addr, logic [15:0] len,
                                          logic [7:0] sbits);
    logic [31:0] w;
    logic [21:0] sum;
    sum = '0;
    case (op)
      edrm_pkg::OP_INIT: begin
        rebuild_rings();
        pending_results.push_back(mk(edrm_pkg::K_ACK));
      end
      edrm_pkg::OP_GRANT: begin
        if (tx_full || (tx_word[tx_give] & {16'h0, edrm_pkg::TXF_READY}) != 0) begin
          pending_results.push_back(mk(edrm_pkg::K_REFUSE));
        end else begin
          pending_results.push_back(mk(edrm_pkg::K_GRANT, tx_buf[tx_give]));
          tx_give = (tx_give + 1) % NTx;
          if (tx_give == tx_send) tx_full = 1'b1;
        end
      end
      edrm_pkg::OP_SUBMIT: begin
        tx_buf[tx_send]  = addr;
        tx_word[tx_send] = (tx_word[tx_send] & {16'h0, ~edrm_pkg::TXF_STATS})
                           | {len, edrm_pkg::TXF_READY};
        tx_send = (tx_send + 1) % NTx;
        tx_full = 1'b0;
        pending_results.push_back(mk(edrm_pkg::K_QUEUED));
      end
      edrm_pkg::OP_POLL: begin
        // Walk until an empty descriptor; bad frames are skipped but re-armed.
        for (int s = 0; s < NRx; s++) begin
          w = rx_word[rx_check];
          if ((w & {16'h0, edrm_pkg::RXF_EMPTY}) != 0) break;
          if ((w[6:0] & err_mask_q) == 0) begin
            pending_results.push_back(mk(edrm_pkg::K_FRAME, rx_buf[rx_check], w[31:16],
                                         '0, 1'b0));
            sum += w[31:16];
          end
          rx_word[rx_check] = (w & ~{16'h0, edrm_pkg::RXF_STATS})
                              | {16'h0, edrm_pkg::RXF_EMPTY};
          rx_check = (rx_check + 1) % NRx;
        end
        pending_results.push_back(mk(edrm_pkg::K_DONE, '0, '0, sum));
      end
      edrm_pkg::OP_TXDONE: begin
        if (slot < NTx)
          tx_word[slot] = (tx_word[slot] & ~{16'h0, edrm_pkg::TXF_READY | 16'h00FF})
                          | {24'h0, sbits};
        pending_results.push_back(mk(edrm_pkg::K_ACK));
      end
      edrm_pkg::OP_RXDONE: begin
        if (slot < NRx)
          rx_word[slot] = {len, rx_word[slot][15:0] & ~(edrm_pkg::RXF_EMPTY | 16'h00FF)}
                          | {24'h0, sbits};
        pending_results.push_back(mk(edrm_pkg::K_ACK));
      end
      default: pending_results.push_back(mk(edrm_pkg::K_ACK));
    endcase
  endfunction

  // Input driver: offers one transfer and holds it until it is accepted.
  // The valid stays high into the next call unless that call idles.
  task automatic send_op(logic [2:0] op, logic [5:0] slot, logic [31:0] addr,
                         logic [15:0] len, logic [7:0] sbits);
    if (!no_idle && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (!no_idle && $urandom_range(99) < 9);
    end
    s_axis_tdata  <= {7'b0, sbits, len, addr, slot, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_ring_op(op, slot, addr, len, sbits);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (NRx + 6) @(posedge clk_i);
  endtask

  // Register writes happen only while the block is drained.
  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == edrm_pkg::REG_DATA_BASE) base_q = val;
    else err_mask_q = val[6:0];
    @(posedge clk_i);
  endtask

  // Random command generator: mostly in-range slots and known operation codes
  // (grants, submissions, completions, polls, rebuilds), some out-of-range slots and unknown codes.
  task automatic send_random_op();
    int unsigned pick;
    logic [5:0]  slot;
    pick = $urandom_range(99);
    slot = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
    if (pick < 18)
      send_op(edrm_pkg::OP_GRANT, slot, $urandom, 16'($urandom), 8'($urandom));
    else if (pick < 34)
      send_op(edrm_pkg::OP_SUBMIT, slot, $urandom, 16'($urandom), 8'($urandom));
    else if (pick < 44)
      send_op(edrm_pkg::OP_TXDONE, slot, $urandom, 16'($urandom), 8'($urandom));
    else if (pick < 70) begin
      // Mostly clean receive status so frames get delivered.
      send_op(edrm_pkg::OP_RXDONE, slot, $urandom, 16'($urandom),
              ($urandom_range(2) == 0) ? 8'($urandom) : {1'($urandom), 7'b0});
    end
    else if (pick < 92)
      send_op(edrm_pkg::OP_POLL, slot, $urandom, 16'($urandom), 8'($urandom));
    else if (pick < 96)
      send_op(edrm_pkg::OP_INIT, slot, $urandom, 16'($urandom), 8'($urandom));
    else send_op(3'($urandom_range(7, 6)), slot, $urandom, 16'($urandom), 8'($urandom));
  endtask

  // Output side: random back-pressure, plus the long hold-off when asked.
  always @(posedge clk_i) begin
    m_axis_tready <= !rx_hold && (no_idle || $urandom_range(99) >= 9);
  end

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    ring_result_t exp_r;
    ring_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = mk(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32],
               m_axis_tdata[69:48], m_axis_tlast);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $realtime, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.kind !== exp_r.kind) begin
          $display("%0t: kind expected %0d actual %0d", $realtime, exp_r.kind, got.kind);
          errors++;
        end
        if (got.addr !== exp_r.addr) begin
          $display("%0t: address expected %h actual %h", $realtime, exp_r.addr, got.addr);
          errors++;
        end
        if (got.len !== exp_r.len) begin
          $display("%0t: length expected %h actual %h", $realtime, exp_r.len, got.len);
          errors++;
        end
        if (got.total !== exp_r.total) begin
          $display("%0t: total expected %h actual %h", $realtime, exp_r.total, got.total);
          errors++;
        end
        if (got.last !== exp_r.last) begin
          $display("%0t: last expected %b actual %b", $realtime, exp_r.last, got.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no transfer at all.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("eth_descriptor_ring_manager regression: fail");
      $finish;
    end
  end

  // Directed table: reset state, grants to a full ring, refusals, submissions, polls,
  // receive completions with errors, out-of-range slots, unknown codes and a rebuild.
  ring_row_t directed[$];

  task automatic add_row(logic [2:0] op, logic [5:0] slot, logic [31:0] addr,
                         logic [15:0] len, logic [7:0] sbits,
                         bit chk = 1'b0, ring_result_t r = '0);
    ring_row_t row;
    row.op = op; row.slot = slot; row.addr = addr; row.len = len;
    row.sbits = sbits; row.chk_first = chk; row.first = r;
    directed.push_back(row);
  endtask

  initial begin
    ring_result_t exp_first;
    base_q = '0; err_mask_q = 7'h7F;
    rebuild_rings();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset slot 0 is granted at address zero; the ring then fills.
    add_row(edrm_pkg::OP_GRANT, '0, '0, '0, '0, 1'b1, mk(edrm_pkg::K_GRANT, 32'h0));
    for (int i = 1; i < 8; i++) add_row(edrm_pkg::OP_GRANT, '0, '0, '0, '0);
    add_row(edrm_pkg::OP_GRANT, '0, '0, '0, '0, 1'b1, mk(edrm_pkg::K_REFUSE));
    add_row(edrm_pkg::OP_SUBMIT, '0, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1,
            mk(edrm_pkg::K_QUEUED));
    // The give slot is now marked ready, so the grant is still refused.
    add_row(edrm_pkg::OP_GRANT, '0, '0, '0, '0, 1'b1, mk(edrm_pkg::K_REFUSE));
    add_row(edrm_pkg::OP_TXDONE, '0, '0, '0, 8'hFF, 1'b1, mk(edrm_pkg::K_ACK));
    add_row(edrm_pkg::OP_TXDONE, 6'd63, '0, '0, 8'hFF, 1'b1, mk(edrm_pkg::K_ACK));
    add_row(edrm_pkg::OP_RXDONE, 6'd0, '0, 16'hFFFF, 8'h00);
    add_row(edrm_pkg::OP_RXDONE, 6'd1, '0, 16'h0040, 8'h01);   // error bit 0 set: dropped
    add_row(edrm_pkg::OP_RXDONE, 6'd2, '0, 16'h0000, 8'h80);   // not an error bit
    add_row(edrm_pkg::OP_RXDONE, 6'd63, '0, 16'h1234, 8'h00, 1'b1, mk(edrm_pkg::K_ACK));
    add_row(edrm_pkg::OP_POLL, '0, '0, '0, '0);
    add_row(edrm_pkg::OP_POLL, '0, '0, '0, '0, 1'b1, mk(edrm_pkg::K_DONE));   // nothing left
    for (int i = 0; i < 8; i++) add_row(edrm_pkg::OP_RXDONE, 6'(i), '0, 16'hFFFF, 8'h00);
    add_row(edrm_pkg::OP_POLL, '0, '0, '0, '0);                     // full walk of the ring
    add_row(3'd6, 6'h2A, 32'h5555_AAAA, 16'hAAAA, 8'h55, 1'b1, mk(edrm_pkg::K_ACK));
    add_row(3'd7, '0, '0, '0, '0, 1'b1, mk(edrm_pkg::K_ACK));
    add_row(edrm_pkg::OP_INIT, '0, '0, '0, '0, 1'b1, mk(edrm_pkg::K_ACK));

    foreach (directed[i]) begin
      if (directed[i].chk_first) begin
        // The typed-in value must agree with the prediction made on acceptance.
        send_op(directed[i].op, directed[i].slot, directed[i].addr,
                directed[i].len, directed[i].sbits);
        exp_first = pending_results[pending_results.size() - 1];
        if (exp_first !== directed[i].first) begin
          $display("%0t: row %0d expected %h actual %h", $realtime, i,
                   directed[i].first, exp_first);
          errors++;
        end
      end else begin
        send_op(directed[i].op, directed[i].slot, directed[i].addr,
                directed[i].len, directed[i].sbits);
      end
    end
    wait_drained();

    // Extreme base address and an empty error mask, then rebuild the pools.
    write_reg(edrm_pkg::REG_DATA_BASE, 32'hFFFF_F800);
    write_reg(edrm_pkg::REG_ERR_MASK, 32'h0);
    send_op(edrm_pkg::OP_INIT, '0, '0, '0, '0);
    for (int i = 0; i < 35; i++) send_random_op();

    // Long receiver hold-off while the sender keeps offering transfers.
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 25; i++) send_random_op();
    join
    // Sender pauses until every expected result has come.
    wait_drained();

    write_reg(edrm_pkg::REG_DATA_BASE, $urandom);
    write_reg(edrm_pkg::REG_ERR_MASK, 32'h7F);
    send_op(edrm_pkg::OP_INIT, '0, '0, '0, '0);
    no_idle = 1'b1;
    for (int i = 0; i < 30; i++) send_random_op();
    wait_drained();
    no_idle = 1'b0;

    write_reg(edrm_pkg::REG_ERR_MASK, 32'($urandom_range(127)));
    for (int i = 0; i < 30; i++) send_random_op();

    wait_drained();
    if (errors == 0) begin
      $display("eth_descriptor_ring_manager regression: pass");
    end else begin
      $display("eth_descriptor_ring_manager regression: fail");
    end
    $finish;
  end

endmodule
